/* src/oadc_pkg.sv */
// shared types, codes, constants and the distance filter for the drive controller
// no dependencies; used by the autopilot, the top level and the testbench
package oadc_pkg;

	localparam logic [8:0] SENSOR_MAX   = 9'd400;
	localparam logic [9:0] SPEED_MAX    = 10'd1000;
	localparam logic [9:0] ZERO_DIST    = 10'd999;
	localparam logic [15:0] DIV10_RECIP = 16'd52429;	// ceil(2^19 / 10)
	localparam int DIV10_SHIFT          = 19;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_FRONT_SAFE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_EMERG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAN_SPEED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OFFSET = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd7;

	localparam logic [1:0] CH_LEFT   = 2'd0;
	localparam logic [1:0] CH_CENTRE = 2'd1;
	localparam logic [1:0] CH_RIGHT  = 2'd2;

	// command characters
	localparam logic [7:0] KEY_A_LO = 8'h61;
	localparam logic [7:0] KEY_A_UP = 8'h41;
	localparam logic [7:0] KEY_M_LO = 8'h6d;
	localparam logic [7:0] KEY_M_UP = 8'h4d;
	localparam logic [7:0] KEY_C_LO = 8'h63;
	localparam logic [7:0] KEY_C_UP = 8'h43;
	localparam logic [7:0] KEY_H_LO = 8'h68;
	localparam logic [7:0] KEY_H_UP = 8'h48;
	localparam logic [7:0] KEY_L_LO = 8'h6c;
	localparam logic [7:0] KEY_L_UP = 8'h4c;
	localparam logic [7:0] KEY_F_LO = 8'h66;
	localparam logic [7:0] KEY_F_UP = 8'h46;
	localparam logic [7:0] KEY_B_LO = 8'h62;
	localparam logic [7:0] KEY_B_UP = 8'h42;
	localparam logic [7:0] KEY_R_LO = 8'h72;
	localparam logic [7:0] KEY_R_UP = 8'h52;
	localparam logic [7:0] KEY_S_LO = 8'h73;
	localparam logic [7:0] KEY_S_UP = 8'h53;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_COMMAND = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		MC_STOP  = 3'd0,
		MC_FWD   = 3'd1,
		MC_BACK  = 3'd2,
		MC_SPINL = 3'd3,
		MC_SPINR = 3'd4,
		MC_DIFF  = 3'd5,
		MC_NONE  = 3'd6
	} motor_cmd_t;

	typedef enum logic [2:0] {
		LD_STOP  = 3'd0,
		LD_FWD   = 3'd1,
		LD_BACK  = 3'd2,
		LD_LEFT  = 3'd3,
		LD_RIGHT = 3'd4
	} light_dir_t;

	typedef enum logic [1:0] {
		MODE_MANUAL = 2'd0,
		MODE_AUTO   = 2'd1,
		MODE_CTRL   = 2'd2
	} drive_mode_t;

	typedef enum logic [1:0] {
		BZ_NONE = 2'd0,
		BZ_IDLE = 2'd1,
		BZ_HORN = 2'd2,
		BZ_REV  = 2'd3
	} buzzer_t;

	typedef struct packed {
		logic [8:0] front_safe_distance;
		logic [8:0] side_emergency_distance;
		logic [9:0] base_speed;
		logic [9:0] spin_speed;
		logic [9:0] manual_speed;
		logic [5:0] steer_gain;
		logic [9:0] steer_clamp;
		logic [3:0] deadband;
	} cfg_t;

	typedef logic [2:0][8:0] dist_t;

	typedef struct packed {
		motor_cmd_t mc;
		logic [9:0] ls;
		logic [9:0] rs;
		light_dir_t lt;
	} drive_t;

	typedef struct packed {
		motor_cmd_t  motor_command;
		logic [9:0]  left_speed;
		logic [9:0]  right_speed;
		light_dir_t  light_direction;
		drive_mode_t drive_mode;
		logic        headlight;
		buzzer_t     buzzer_request;
	} result_t;

	function automatic logic [9:0] sat1000(input logic [9:0] v);
		return (v > SPEED_MAX) ? SPEED_MAX : v;
	endfunction

	// clamp the raw reading, then replace or blend 30/70 with the stored value
	function automatic logic [8:0] filt_step(input logic [8:0] prev, input logic [9:0] raw);
		logic [8:0]  cur;
		logic [12:0] sum;
		logic [28:0] prod;
		cur = (raw == 10'd0 || raw > {1'b0, SENSOR_MAX}) ? SENSOR_MAX : raw[8:0];
		sum = 13'(prev) * 13'd3 + 13'(cur) * 13'd7;
		prod = 29'(sum) * 29'(DIV10_RECIP);
		if (prev == 9'd0 || prev == SENSOR_MAX)
			return cur;
		return 9'(prod >> DIV10_SHIFT);
	endfunction

endpackage

/* src/oadc_if.sv */
// valid/ready channel interfaces for input items and result items
// depends on nothing; field widths follow the controller's item format
interface oadc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [1:0] sensor_channel;
	logic [9:0] distance_raw;
	logic [7:0] command_byte;

	modport source(output valid, op, sensor_channel, distance_raw, command_byte,
		input ready);
	modport sink(input valid, op, sensor_channel, distance_raw, command_byte,
		output ready);
endinterface

interface oadc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] motor_command;
	logic [9:0] left_speed;
	logic [9:0] right_speed;
	logic [2:0] light_direction;
	logic [1:0] drive_mode;
	logic       headlight;
	logic [1:0] buzzer_request;

	modport source(output valid, motor_command, left_speed, right_speed, light_direction,
		drive_mode, headlight, buzzer_request, input ready);
	modport sink(input valid, motor_command, left_speed, right_speed, light_direction,
		drive_mode, headlight, buzzer_request, output ready);
endinterface

/* src/oadc_autopilot.sv */
// autonomous-mode motor decision: spin away from walls or steer proportionally
// depends on oadc_pkg (cfg_t, dist_t, drive_t, sat1000)
module oadc_autopilot (
	input  oadc_pkg::cfg_t   cfg,
	input  oadc_pkg::dist_t  dists,
	output oadc_pkg::drive_t drv
);

	logic [9:0]         l, c, r, spin;
	logic signed [10:0] diff, dz, db;
	logic signed [17:0] off, lim;
	logic signed [10:0] offc;
	logic signed [11:0] lv, rv;

	always_comb begin
		// a stored zero reads as far away
		l = (dists[oadc_pkg::CH_LEFT] == 9'd0) ? oadc_pkg::ZERO_DIST
			: {1'b0, dists[oadc_pkg::CH_LEFT]};
		c = (dists[oadc_pkg::CH_CENTRE] == 9'd0) ? oadc_pkg::ZERO_DIST
			: {1'b0, dists[oadc_pkg::CH_CENTRE]};
		r = (dists[oadc_pkg::CH_RIGHT] == 9'd0) ? oadc_pkg::ZERO_DIST
			: {1'b0, dists[oadc_pkg::CH_RIGHT]};
		spin = oadc_pkg::sat1000(cfg.spin_speed);

		diff = $signed({1'b0, l}) - $signed({1'b0, r});
		db   = $signed({7'd0, cfg.deadband});
		dz   = (diff >= -db && diff <= db) ? 11'sd0 : diff;
		off  = 18'(dz) * $signed({12'd0, cfg.steer_gain});
		lim  = $signed({8'd0, cfg.steer_clamp});
		if (off > lim)
			offc = 11'(lim);
		else if (off < -lim)
			offc = 11'(-lim);
		else
			offc = 11'(off);
		lv = $signed({2'b0, cfg.base_speed}) - 12'(offc);
		rv = $signed({2'b0, cfg.base_speed}) + 12'(offc);

		drv.rs = 10'd0;
		drv.ls = spin;
		if (c < {1'b0, cfg.front_safe_distance}) begin
			if (l >= r) begin
				drv.mc = oadc_pkg::MC_SPINL;
				drv.lt = oadc_pkg::LD_LEFT;
			end else begin
				drv.mc = oadc_pkg::MC_SPINR;
				drv.lt = oadc_pkg::LD_RIGHT;
			end
		end else if (l < {1'b0, cfg.side_emergency_distance}) begin
			drv.mc = oadc_pkg::MC_SPINR;
			drv.lt = oadc_pkg::LD_RIGHT;
		end else if (r < {1'b0, cfg.side_emergency_distance}) begin
			drv.mc = oadc_pkg::MC_SPINL;
			drv.lt = oadc_pkg::LD_LEFT;
		end else begin
			drv.mc = oadc_pkg::MC_DIFF;
			drv.lt = oadc_pkg::LD_FWD;
			if (lv < 12'sd0)
				drv.ls = 10'd0;
			else if (lv > $signed({2'b0, oadc_pkg::SPEED_MAX}))
				drv.ls = oadc_pkg::SPEED_MAX;
			else
				drv.ls = lv[9:0];
			if (rv < 12'sd0)
				drv.rs = 10'd0;
			else if (rv > $signed({2'b0, oadc_pkg::SPEED_MAX}))
				drv.rs = oadc_pkg::SPEED_MAX;
			else
				drv.rs = rv[9:0];
		end
	end

endmodule

/* src/obstacle_avoid_drive_controller_top.sv */
// obstacle-avoiding drive controller: filters, command decoder, motor decision
// depends on oadc_pkg, oadc_if (oadc_req_if, oadc_rsp_if) and oadc_autopilot
//
//  port      | direction | contents
//  ----------+-----------+-----------------------------------------------------
//  req       | in        | op, sensor_channel, distance_raw, command_byte
//  rsp       | out       | motor_command, speeds, light_direction, mode, etc.
//  cfg_*     | in        | write enable, register index, write data
//
// every item gives exactly one result item, through the input stage and then the result register
// one item per cycle while the result side does not stall: all the work sits between the input stage and
// the result register, with filter, decoder and steering in a single pass
// arst_n clears the stages, the mode, direction and headlight, sets the
// distances to the sensor maximum and the registers to their defaults
// a stalled result holds the input stage; req.ready drops only when both are full
module obstacle_avoid_drive_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [oadc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oadc_pkg::CFG_DATA_W-1:0] cfg_data,
	oadc_req_if.sink                        req,
	oadc_rsp_if.source                      rsp
);

	// configuration registers
	oadc_pkg::cfg_t cfg_q;

	// controller state
	logic [8:0]            dist_q [3];
	oadc_pkg::drive_mode_t mode_q;
	oadc_pkg::light_dir_t  dir_q;
	logic                  hl_q;

	// input stage
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [1:0] ch_s1;
	logic [9:0] raw_s1;
	logic [7:0] cb_s1;

	// result register
	logic              out_valid_q;
	oadc_pkg::result_t result_q;

	// next state and result
	logic [8:0]            dist_d [3];
	oadc_pkg::drive_mode_t mode_d;
	oadc_pkg::light_dir_t  dir_d;
	logic                  hl_d;
	oadc_pkg::result_t     res;
	oadc_pkg::dist_t       dist_pk;
	oadc_pkg::drive_t      auto_drv;
	logic                  dir_hit;
	oadc_pkg::light_dir_t  dir_new;
	logic                  advance;

	// input stage moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_safe_distance     <= 9'd25;
			cfg_q.side_emergency_distance <= 9'd7;
			cfg_q.base_speed              <= 10'd700;
			cfg_q.spin_speed              <= 10'd750;
			cfg_q.manual_speed            <= 10'd800;
			cfg_q.steer_gain              <= 6'd15;
			cfg_q.steer_clamp             <= 10'd200;
			cfg_q.deadband                <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				oadc_pkg::CFG_FRONT_SAFE: cfg_q.front_safe_distance     <= cfg_data[8:0];
				oadc_pkg::CFG_SIDE_EMERG: cfg_q.side_emergency_distance <= cfg_data[8:0];
				oadc_pkg::CFG_BASE_SPEED: cfg_q.base_speed              <= cfg_data;
				oadc_pkg::CFG_SPIN_SPEED: cfg_q.spin_speed              <= cfg_data;
				oadc_pkg::CFG_MAN_SPEED:  cfg_q.manual_speed            <= cfg_data;
				oadc_pkg::CFG_STEER_GAIN: cfg_q.steer_gain              <= cfg_data[5:0];
				oadc_pkg::CFG_MAX_OFFSET: cfg_q.steer_clamp             <= cfg_data;
				oadc_pkg::CFG_DEADBAND:   cfg_q.deadband                <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input stage capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= req.op;
			ch_s1  <= req.sensor_channel;
			raw_s1 <= req.distance_raw;
			cb_s1  <= req.command_byte;
		end
	end

	assign dist_pk[oadc_pkg::CH_LEFT]   = dist_q[0];
	assign dist_pk[oadc_pkg::CH_CENTRE] = dist_q[1];
	assign dist_pk[oadc_pkg::CH_RIGHT]  = dist_q[2];

	oadc_autopilot u_autopilot (
		.cfg   (cfg_q),
		.dists (dist_pk),
		.drv   (auto_drv)
	);

	// item decode and state update, all in one pass
	always_comb begin
		dist_d  = dist_q;
		mode_d  = mode_q;
		dir_d   = dir_q;
		hl_d    = hl_q;
		dir_hit = 1'b0;
		dir_new = oadc_pkg::LD_STOP;

		res.motor_command   = oadc_pkg::MC_NONE;
		res.left_speed      = 10'd0;
		res.right_speed     = 10'd0;
		res.light_direction = oadc_pkg::LD_STOP;
		res.buzzer_request  = oadc_pkg::BZ_NONE;

		case (oadc_pkg::op_t'(op_s1))
			oadc_pkg::OP_SAMPLE: begin
				case (ch_s1)
					oadc_pkg::CH_LEFT:   dist_d[0] = oadc_pkg::filt_step(dist_q[0], raw_s1);
					oadc_pkg::CH_CENTRE: dist_d[1] = oadc_pkg::filt_step(dist_q[1], raw_s1);
					oadc_pkg::CH_RIGHT:  dist_d[2] = oadc_pkg::filt_step(dist_q[2], raw_s1);
					default: ;	// no fourth sensor
				endcase
			end
			oadc_pkg::OP_COMMAND: begin
				if (cb_s1 inside {oadc_pkg::KEY_A_LO, oadc_pkg::KEY_A_UP}) begin
					mode_d                = oadc_pkg::MODE_AUTO;
					res.motor_command     = oadc_pkg::MC_STOP;
					res.buzzer_request    = oadc_pkg::BZ_IDLE;
				end else if (cb_s1 inside {oadc_pkg::KEY_M_LO, oadc_pkg::KEY_M_UP}) begin
					mode_d                = oadc_pkg::MODE_MANUAL;
					dir_d                 = oadc_pkg::LD_STOP;
					res.motor_command     = oadc_pkg::MC_STOP;
					res.buzzer_request    = oadc_pkg::BZ_IDLE;
				end else if (cb_s1 inside {oadc_pkg::KEY_C_LO, oadc_pkg::KEY_C_UP}) begin
					mode_d                = oadc_pkg::MODE_CTRL;
					res.motor_command     = oadc_pkg::MC_STOP;
					res.buzzer_request    = oadc_pkg::BZ_IDLE;
				end else if (cb_s1 inside {oadc_pkg::KEY_H_LO, oadc_pkg::KEY_H_UP}) begin
					res.buzzer_request    = oadc_pkg::BZ_HORN;
				end else if (cb_s1 == oadc_pkg::KEY_L_UP) begin
					// capital L is always the headlight, never left
					hl_d = !hl_q;
				end else if (mode_q != oadc_pkg::MODE_AUTO) begin
					dir_hit = 1'b1;
					if (cb_s1 inside {oadc_pkg::KEY_F_LO, oadc_pkg::KEY_F_UP})
						dir_new = oadc_pkg::LD_FWD;
					else if (cb_s1 inside {oadc_pkg::KEY_B_LO, oadc_pkg::KEY_B_UP})
						dir_new = oadc_pkg::LD_BACK;
					else if (cb_s1 == oadc_pkg::KEY_L_LO)
						dir_new = oadc_pkg::LD_LEFT;
					else if (cb_s1 inside {oadc_pkg::KEY_R_LO, oadc_pkg::KEY_R_UP})
						dir_new = oadc_pkg::LD_RIGHT;
					else if (cb_s1 inside {oadc_pkg::KEY_S_LO, oadc_pkg::KEY_S_UP})
						dir_new = oadc_pkg::LD_STOP;
					else
						dir_hit = 1'b0;
					if (dir_hit) begin
						dir_d = dir_new;
						if (dir_new != dir_q)
							res.buzzer_request = (dir_new == oadc_pkg::LD_BACK)
								? oadc_pkg::BZ_REV : oadc_pkg::BZ_IDLE;
					end
				end
			end
			oadc_pkg::OP_TICK: begin
				if (mode_q != oadc_pkg::MODE_AUTO) begin
					// manual and controller modes follow the stored direction
					if (dir_q != oadc_pkg::LD_STOP) begin
						res.motor_command   = oadc_pkg::motor_cmd_t'(3'(dir_q));
						res.left_speed      = oadc_pkg::sat1000(cfg_q.manual_speed);
						res.light_direction = dir_q;
					end else begin
						res.motor_command   = oadc_pkg::MC_STOP;
					end
				end else begin
					res.motor_command   = auto_drv.mc;
					res.left_speed      = auto_drv.ls;
					res.right_speed     = auto_drv.rs;
					res.light_direction = auto_drv.lt;
				end
			end
			default: ;	// unused opcode: result is none
		endcase

		res.drive_mode = mode_d;
		res.headlight  = hl_d;
	end

	// state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q[0] <= oadc_pkg::SENSOR_MAX;
			dist_q[1] <= oadc_pkg::SENSOR_MAX;
			dist_q[2] <= oadc_pkg::SENSOR_MAX;
			mode_q    <= oadc_pkg::MODE_MANUAL;
			dir_q     <= oadc_pkg::LD_STOP;
			hl_q      <= 1'b0;
		end else if (advance) begin
			dist_q <= dist_d;
			mode_q <= mode_d;
			dir_q  <= dir_d;
			hl_q   <= hl_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.motor_command   = result_q.motor_command;
	assign rsp.left_speed      = result_q.left_speed;
	assign rsp.right_speed     = result_q.right_speed;
	assign rsp.light_direction = result_q.light_direction;
	assign rsp.drive_mode      = result_q.drive_mode;
	assign rsp.headlight       = result_q.headlight;
	assign rsp.buzzer_request  = result_q.buzzer_request;

`ifndef NO_ASSERTIONS
	// a waiting item in the input stage is never dropped while the output stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage item lost during stall");

	// differential drive only comes out of autonomous mode
	a_diff_auto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.motor_command == oadc_pkg::MC_DIFF
		|-> result_q.drive_mode == oadc_pkg::MODE_AUTO)
		else $error("differential command outside autonomous mode");

	// filtered distances stay within one to the sensor maximum
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		dist_q[0] != 9'd0 && dist_q[0] <= oadc_pkg::SENSOR_MAX &&
		dist_q[1] != 9'd0 && dist_q[1] <= oadc_pkg::SENSOR_MAX &&
		dist_q[2] != 9'd0 && dist_q[2] <= oadc_pkg::SENSOR_MAX)
		else $error("filtered distance out of range");
`endif

endmodule

/* verif/obstacle_avoid_drive_controller_top_test.sv */
`timescale 1ns / 100ps
// self-checking testbench for the obstacle-avoiding drive controller top level
// depends on oadc_pkg, oadc_if (oadc_req_if, oadc_rsp_if) and the top module
module obstacle_avoid_drive_controller_top_test;

	// codes the package has no name for: spare opcode, spare channel, a stray key
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] CH_NONE     = 2'd3;
	localparam logic [7:0] KEY_UNKNOWN = 8'h78;

	// register set styles for one phase
	localparam int SET_LOW    = 0;
	localparam int SET_HIGH   = 1;
	localparam int SET_RANDOM = 2;

	// length of the long result hold-off that backs the pipe up
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] sensor_channel;
		logic [9:0] distance_raw;
		logic [7:0] command_byte;
	} drive_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [oadc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [oadc_pkg::CFG_DATA_W-1:0] cfg_data;

	oadc_req_if req_ch();
	oadc_rsp_if rsp_ch();

	obstacle_avoid_drive_controller_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #1 clk = ~clk;

	// predictor state: filtered distances, mode, manual direction, headlight, registers
	logic [8:0]            dist_model [3];
	oadc_pkg::drive_mode_t mode_model;
	oadc_pkg::light_dir_t  dir_model;
	logic                  head_model;
	oadc_pkg::cfg_t        cfg_model;

	drive_item_t       pending_items [$];
	oadc_pkg::result_t expected_results [$];
	int                mismatch_count = 0;

	// idling odds per phase, in percent
	int send_idle_pct = 0;
	int stall_pct = 0;

	// long hold-off: the stimulus flips hold_kick, the counter runs on its own
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	logic item_taken = 1'b0;

	// distances the random samples hover around, so the filters settle near them
	int scene [3];

	// what the controller must answer to one item; updates the predictor state
	function automatic oadc_pkg::result_t next_drive_result(drive_item_t it);
		oadc_pkg::result_t    res;
		oadc_pkg::light_dir_t new_dir;
		logic                 dir_cmd;
		int cur, dl, dc, dr, spin, diff, db, lim, off, lv, rv;
		res.motor_command   = oadc_pkg::MC_NONE;
		res.left_speed      = '0;
		res.right_speed     = '0;
		res.light_direction = oadc_pkg::LD_STOP;
		res.buzzer_request  = oadc_pkg::BZ_NONE;
		new_dir = oadc_pkg::LD_STOP;
		dir_cmd = 1'b0;
		case (it.op)
		oadc_pkg::OP_SAMPLE: begin
			// out-of-range reading means nothing in sight; a fresh filter takes it whole
			if (it.sensor_channel != CH_NONE) begin
				cur = (it.distance_raw == 0 || it.distance_raw > oadc_pkg::SENSOR_MAX) ?
					oadc_pkg::SENSOR_MAX : it.distance_raw;
				if (dist_model[it.sensor_channel] == 0 ||
						dist_model[it.sensor_channel] == oadc_pkg::SENSOR_MAX)
					dist_model[it.sensor_channel] = 9'(cur);
				else
					dist_model[it.sensor_channel] =
						9'((3 * dist_model[it.sensor_channel] + 7 * cur) / 10);
			end
		end
		oadc_pkg::OP_COMMAND: begin
			case (it.command_byte)
			oadc_pkg::KEY_A_LO, oadc_pkg::KEY_A_UP: begin
				mode_model = oadc_pkg::MODE_AUTO;
				res.motor_command = oadc_pkg::MC_STOP;
				res.buzzer_request = oadc_pkg::BZ_IDLE;
			end
			oadc_pkg::KEY_M_LO, oadc_pkg::KEY_M_UP: begin
				mode_model = oadc_pkg::MODE_MANUAL;
				dir_model = oadc_pkg::LD_STOP;
				res.motor_command = oadc_pkg::MC_STOP;
				res.buzzer_request = oadc_pkg::BZ_IDLE;
			end
			oadc_pkg::KEY_C_LO, oadc_pkg::KEY_C_UP: begin
				mode_model = oadc_pkg::MODE_CTRL;
				res.motor_command = oadc_pkg::MC_STOP;
				res.buzzer_request = oadc_pkg::BZ_IDLE;
			end
			oadc_pkg::KEY_H_LO, oadc_pkg::KEY_H_UP: res.buzzer_request = oadc_pkg::BZ_HORN;
			// capital L is always the headlight, never a left turn
			oadc_pkg::KEY_L_UP: head_model = ~head_model;
			oadc_pkg::KEY_F_LO, oadc_pkg::KEY_F_UP: begin
				new_dir = oadc_pkg::LD_FWD;
				dir_cmd = 1'b1;
			end
			oadc_pkg::KEY_B_LO, oadc_pkg::KEY_B_UP: begin
				new_dir = oadc_pkg::LD_BACK;
				dir_cmd = 1'b1;
			end
			oadc_pkg::KEY_L_LO: begin
				new_dir = oadc_pkg::LD_LEFT;
				dir_cmd = 1'b1;
			end
			oadc_pkg::KEY_R_LO, oadc_pkg::KEY_R_UP: begin
				new_dir = oadc_pkg::LD_RIGHT;
				dir_cmd = 1'b1;
			end
			oadc_pkg::KEY_S_LO, oadc_pkg::KEY_S_UP: begin
				new_dir = oadc_pkg::LD_STOP;
				dir_cmd = 1'b1;
			end
			default: ;
			endcase
			// direction keys only count outside autonomous mode, and beep only on a change
			if (dir_cmd && mode_model != oadc_pkg::MODE_AUTO) begin
				if (new_dir != dir_model)
					res.buzzer_request = (new_dir == oadc_pkg::LD_BACK) ?
						oadc_pkg::BZ_REV : oadc_pkg::BZ_IDLE;
				dir_model = new_dir;
			end
		end
		oadc_pkg::OP_TICK: begin
			if (mode_model != oadc_pkg::MODE_AUTO) begin
				if (dir_model != oadc_pkg::LD_STOP) begin
					res.motor_command = oadc_pkg::motor_cmd_t'(dir_model);
					res.left_speed = (cfg_model.manual_speed > oadc_pkg::SPEED_MAX) ?
						oadc_pkg::SPEED_MAX : cfg_model.manual_speed;
					res.light_direction = dir_model;
				end else
					res.motor_command = oadc_pkg::MC_STOP;
			end else begin
				dl = (dist_model[oadc_pkg::CH_LEFT] == 0) ? oadc_pkg::ZERO_DIST :
					dist_model[oadc_pkg::CH_LEFT];
				dc = (dist_model[oadc_pkg::CH_CENTRE] == 0) ? oadc_pkg::ZERO_DIST :
					dist_model[oadc_pkg::CH_CENTRE];
				dr = (dist_model[oadc_pkg::CH_RIGHT] == 0) ? oadc_pkg::ZERO_DIST :
					dist_model[oadc_pkg::CH_RIGHT];
				spin = (cfg_model.spin_speed > oadc_pkg::SPEED_MAX) ?
					oadc_pkg::SPEED_MAX : cfg_model.spin_speed;
				if (dc < cfg_model.front_safe_distance) begin
					// wall ahead: spin toward the more open side, left on a tie
					if (dl >= dr) begin
						res.motor_command = oadc_pkg::MC_SPINL;
						res.light_direction = oadc_pkg::LD_LEFT;
					end else begin
						res.motor_command = oadc_pkg::MC_SPINR;
						res.light_direction = oadc_pkg::LD_RIGHT;
					end
					res.left_speed = 10'(spin);
				end else if (dl < cfg_model.side_emergency_distance) begin
					res.motor_command = oadc_pkg::MC_SPINR;
					res.light_direction = oadc_pkg::LD_RIGHT;
					res.left_speed = 10'(spin);
				end else if (dr < cfg_model.side_emergency_distance) begin
					res.motor_command = oadc_pkg::MC_SPINL;
					res.light_direction = oadc_pkg::LD_LEFT;
					res.left_speed = 10'(spin);
				end else begin
					// proportional steering with deadband, offset clamp and wheel clamp
					diff = dl - dr;
					db = int'(cfg_model.deadband);
					lim = int'(cfg_model.steer_clamp);
					if (diff >= -db && diff <= db)
						diff = 0;
					off = diff * int'(cfg_model.steer_gain);
					if (off > lim)
						off = lim;
					if (off < -lim)
						off = -lim;
					lv = int'(cfg_model.base_speed) - off;
					rv = int'(cfg_model.base_speed) + off;
					if (lv < 0)
						lv = 0;
					if (lv > int'(oadc_pkg::SPEED_MAX))
						lv = oadc_pkg::SPEED_MAX;
					if (rv < 0)
						rv = 0;
					if (rv > int'(oadc_pkg::SPEED_MAX))
						rv = oadc_pkg::SPEED_MAX;
					res.motor_command = oadc_pkg::MC_DIFF;
					res.left_speed = 10'(lv);
					res.right_speed = 10'(rv);
					res.light_direction = oadc_pkg::LD_FWD;
				end
			end
		end
		default: ;
		endcase
		res.drive_mode = mode_model;
		res.headlight = head_model;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void push_item(logic [1:0] op, logic [1:0] ch, logic [9:0] raw,
			logic [7:0] cb);
		pending_items.push_back({op, ch, raw, cb});
	endfunction

	// mostly open space, now and then something close
	function automatic int pick_distance();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 400);
	endfunction

	// random item: mostly plausible driving traffic, with noise mixed in
	function automatic drive_item_t random_item();
		drive_item_t it;
		int   pick;
		int   ch;
		logic up;
		it.op = oadc_pkg::OP_SAMPLE;
		it.sensor_channel = 2'($urandom);
		it.distance_raw = 10'($urandom);
		it.command_byte = 8'($urandom);
		// move the scene now and then; half the time left and right nearly match
		if ($urandom_range(0, 15) == 0) begin
			scene[oadc_pkg::CH_LEFT] = pick_distance();
			scene[oadc_pkg::CH_CENTRE] = ($urandom_range(0, 2) == 0) ?
				$urandom_range(1, 60) : pick_distance();
			scene[oadc_pkg::CH_RIGHT] = ($urandom_range(0, 1) == 0) ?
				scene[oadc_pkg::CH_LEFT] + $urandom_range(0, 8) - 4 : pick_distance();
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// one sample in ten keeps its fully random channel and reading
			if ($urandom_range(0, 9) != 0) begin
				ch = $urandom_range(0, 2);
				it.sensor_channel = 2'(ch);
				it.distance_raw = 10'(scene[ch] + $urandom_range(0, 2));
			end
		end else if (pick < 65) begin
			it.op = oadc_pkg::OP_COMMAND;
			// a few stray bytes, the rest real keys in either case
			if ($urandom_range(0, 6) != 0) begin
				up = 1'($urandom);
				case ($urandom_range(0, 8))
				0: it.command_byte = up ? oadc_pkg::KEY_A_UP : oadc_pkg::KEY_A_LO;
				1: it.command_byte = up ? oadc_pkg::KEY_M_UP : oadc_pkg::KEY_M_LO;
				2: it.command_byte = up ? oadc_pkg::KEY_C_UP : oadc_pkg::KEY_C_LO;
				3: it.command_byte = up ? oadc_pkg::KEY_H_UP : oadc_pkg::KEY_H_LO;
				4: it.command_byte = up ? oadc_pkg::KEY_L_UP : oadc_pkg::KEY_L_LO;
				5: it.command_byte = up ? oadc_pkg::KEY_F_UP : oadc_pkg::KEY_F_LO;
				6: it.command_byte = up ? oadc_pkg::KEY_B_UP : oadc_pkg::KEY_B_LO;
				7: it.command_byte = up ? oadc_pkg::KEY_R_UP : oadc_pkg::KEY_R_LO;
				default: it.command_byte = up ? oadc_pkg::KEY_S_UP : oadc_pkg::KEY_S_LO;
				endcase
			end
		end else if (pick < 95)
			it.op = oadc_pkg::OP_TICK;
		else
			it.op = OP_UNUSED;
		return it;
	endfunction

	// register write on the falling edge; the block takes it at the next rising edge
	task automatic write_reg(logic [oadc_pkg::CFG_IDX_W-1:0] idx,
			logic [oadc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		oadc_pkg::CFG_FRONT_SAFE: cfg_model.front_safe_distance = val[8:0];
		oadc_pkg::CFG_SIDE_EMERG: cfg_model.side_emergency_distance = val[8:0];
		oadc_pkg::CFG_BASE_SPEED: cfg_model.base_speed = val;
		oadc_pkg::CFG_SPIN_SPEED: cfg_model.spin_speed = val;
		oadc_pkg::CFG_MAN_SPEED:  cfg_model.manual_speed = val;
		oadc_pkg::CFG_STEER_GAIN: cfg_model.steer_gain = val[5:0];
		oadc_pkg::CFG_MAX_OFFSET: cfg_model.steer_clamp = val;
		oadc_pkg::CFG_DEADBAND:   cfg_model.deadband = val[3:0];
		default: ;
		endcase
	endtask

	// low gives zero, high the full field width, random mostly a useful range
	function automatic logic [9:0] setting(int kind, int top, int lo, int hi);
		if (kind == SET_LOW)
			return '0;
		if (kind == SET_HIGH)
			return 10'(top);
		if ($urandom_range(0, 7) == 0)
			return 10'($urandom_range(0, top));
		return 10'($urandom_range(lo, hi));
	endfunction

	task automatic load_settings(int kind);
		write_reg(oadc_pkg::CFG_FRONT_SAFE, setting(kind, 511, 5, 80));
		write_reg(oadc_pkg::CFG_SIDE_EMERG, setting(kind, 511, 2, 30));
		write_reg(oadc_pkg::CFG_BASE_SPEED, setting(kind, 1023, 200, 1000));
		write_reg(oadc_pkg::CFG_SPIN_SPEED, setting(kind, 1023, 200, 1023));
		write_reg(oadc_pkg::CFG_MAN_SPEED, setting(kind, 1023, 100, 1023));
		write_reg(oadc_pkg::CFG_STEER_GAIN, setting(kind, 63, 0, 63));
		write_reg(oadc_pkg::CFG_MAX_OFFSET, setting(kind, 1023, 0, 1000));
		write_reg(oadc_pkg::CFG_DEADBAND, setting(kind, 15, 0, 15));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every item went in and every result came back, then let the pipe drain
	task automatic settle();
		while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// driver: a new item goes out only once the one on the bus has been taken
	always @(negedge clk) begin : drive_items
		drive_item_t nxt;
		if (!arst_n)
			req_ch.valid <= 1'b0;
		else if (!req_ch.valid || item_taken) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.op <= nxt.op;
				req_ch.sensor_channel <= nxt.sensor_channel;
				req_ch.distance_raw <= nxt.distance_raw;
				req_ch.command_byte <= nxt.command_byte;
			end else
				req_ch.valid <= 1'b0;
		end
	end

	// result side: random stalls, plus the long hold-off while it runs
	always @(negedge clk) begin : accept_results
		rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
	end

	always @(negedge clk) begin : count_hold
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: check the result first, then predict the item taken on the same edge
	always @(posedge clk) begin : watch_results
		oadc_pkg::result_t want;
		if (!arst_n)
			item_taken <= 1'b0;
		else begin
			item_taken <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: no result expected, got motor_command %0d", $time,
						rsp_ch.motor_command);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("motor_command", want.motor_command, rsp_ch.motor_command);
					check_field("left_speed", want.left_speed, rsp_ch.left_speed);
					check_field("right_speed", want.right_speed, rsp_ch.right_speed);
					check_field("light_direction", want.light_direction,
						rsp_ch.light_direction);
					check_field("drive_mode", want.drive_mode, rsp_ch.drive_mode);
					check_field("headlight", want.headlight, rsp_ch.headlight);
					check_field("buzzer_request", want.buzzer_request, rsp_ch.buzzer_request);
				end
			end
			if (req_ch.valid && req_ch.ready)
				expected_results.push_back(next_drive_result({req_ch.op, req_ch.sensor_channel,
					req_ch.distance_raw, req_ch.command_byte}));
		end
	end

	initial begin : run_stimulus
		int pace;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = oadc_pkg::CFG_FRONT_SAFE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.op = oadc_pkg::OP_SAMPLE;
		req_ch.sensor_channel = oadc_pkg::CH_LEFT;
		req_ch.distance_raw = '0;
		req_ch.command_byte = '0;
		rsp_ch.ready = 1'b0;

		// predictor starts from the reset state
		for (int i = 0; i < 3; i++)
			dist_model[i] = oadc_pkg::SENSOR_MAX;
		mode_model = oadc_pkg::MODE_MANUAL;
		dir_model = oadc_pkg::LD_STOP;
		head_model = 1'b0;
		cfg_model.front_safe_distance = 9'd25;
		cfg_model.side_emergency_distance = 9'd7;
		cfg_model.base_speed = 10'd700;
		cfg_model.spin_speed = 10'd750;
		cfg_model.manual_speed = 10'd800;
		cfg_model.steer_gain = 6'd15;
		cfg_model.steer_clamp = 10'd200;
		cfg_model.deadband = 4'd2;
		scene[oadc_pkg::CH_LEFT] = 150;
		scene[oadc_pkg::CH_CENTRE] = 200;
		scene[oadc_pkg::CH_RIGHT] = 148;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, at the reset register values
		// zero and out-of-range readings clamp; a fresh filter is replaced, then blended
		push_item(oadc_pkg::OP_SAMPLE, oadc_pkg::CH_LEFT, 10'd0, 8'd0);
		push_item(oadc_pkg::OP_SAMPLE, oadc_pkg::CH_CENTRE, 10'd1023, 8'hff);
		push_item(oadc_pkg::OP_SAMPLE, oadc_pkg::CH_RIGHT, 10'd1, 8'd0);
		push_item(oadc_pkg::OP_SAMPLE, oadc_pkg::CH_RIGHT, 10'd512, 8'd0);
		// spare channel and spare opcode are ignored
		push_item(oadc_pkg::OP_SAMPLE, CH_NONE, 10'd55, 8'd0);
		push_item(OP_UNUSED, CH_NONE, 10'h3ff, 8'hff);
		// unknown key, horn, headlight toggle
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, KEY_UNKNOWN);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_H_LO);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_L_UP);
		// manual driving: a repeated direction gives no beep, backward gives the reverse beep
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_F_LO);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_F_UP);
		push_item(oadc_pkg::OP_TICK, oadc_pkg::CH_LEFT, 10'd0, 8'd0);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_B_LO);
		push_item(oadc_pkg::OP_TICK, oadc_pkg::CH_LEFT, 10'd0, 8'd0);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_L_LO);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_R_UP);
		// controller mode keeps the direction keys; stop gives a stop tick
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_C_LO);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_S_UP);
		push_item(oadc_pkg::OP_TICK, oadc_pkg::CH_LEFT, 10'd0, 8'd0);
		// autonomous: lowercase l ignored, front wall spins, then proportional steering
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_A_UP);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_L_LO);
		push_item(oadc_pkg::OP_SAMPLE, oadc_pkg::CH_CENTRE, 10'd10, 8'd0);
		push_item(oadc_pkg::OP_TICK, oadc_pkg::CH_LEFT, 10'd0, 8'd0);
		push_item(oadc_pkg::OP_SAMPLE, oadc_pkg::CH_CENTRE, 10'd300, 8'd0);
		push_item(oadc_pkg::OP_TICK, oadc_pkg::CH_LEFT, 10'd0, 8'd0);
		push_item(oadc_pkg::OP_COMMAND, oadc_pkg::CH_LEFT, 10'd0, oadc_pkg::KEY_M_UP);
		settle();

		// random phases: lowest registers, highest registers, then random settings,
		// each with one of four idling patterns; two phases add the long result hold-off
		for (int ph = 0; ph < 6; ph++) begin
			load_settings((ph == 0) ? SET_LOW : (ph == 1) ? SET_HIGH : SET_RANDOM);
			@(posedge clk);
			pace = (ph + 1) % 4;
			send_idle_pct = (pace == 1) ? 70 : (pace == 3) ? 29 : 0;
			stall_pct = (pace == 2) ? 70 : (pace == 3) ? 29 : 0;
			if (ph == 2 || ph == 3)
				hold_kick = ~hold_kick;
			repeat (130)
				pending_items.push_back(random_item());
			settle();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("obstacle_avoid_drive_controller_top_test: clean");
		else
			$display("obstacle_avoid_drive_controller_top_test: errors");
		$finish;
	end

	// watchdog: a stuck handshake or a lost result ends here
	initial begin : watchdog
		#1000000;
		$display("obstacle_avoid_drive_controller_top_test: errors");
		$finish;
	end

endmodule
